@@ hdl/mjd_pkg.sv @@
// Shared types, sizes and helpers for the multicore job dispatcher.
`timescale 1ns / 1ps
`default_nettype none

package mjd_pkg;

   localparam int CORE_COUNT  = 8;
   localparam int QUEUE_DEPTH = 16;

   localparam int OP_W    = 2;
   localparam int TAG_W   = 16;
   localparam int CORE_W  = 3;
   localparam int ACT_W   = 3;
   localparam int CNT_W   = 5;
   localparam int BUSY_W  = 4;
   localparam int LIMIT_W = 5;
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   localparam int REQ_DATA_W = ((TAG_W + CORE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((TAG_W + CORE_W + CNT_W + BUSY_W + 7) / 8) * 8;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
   localparam logic [CNT_W-1:0]   DEPTH_CNT   = CNT_W'(QUEUE_DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_ARRIVE  = 2'd0,
      OP_END     = 2'd1,
      OP_TIMEOUT = 2'd2,
      OP_UNUSED  = 2'd3
   } mjd_op_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_STARTED  = 3'd0,
      ACT_QUEUED   = 3'd1,
      ACT_DROPPED  = 3'd2,
      ACT_FINISHED = 3'd3,
      ACT_ABORTED  = 3'd4,
      ACT_IGNORED  = 3'd5
   } mjd_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_SECOND
   } mjd_state_type;

   // round-robin search result
   typedef struct packed {
      logic              found;
      logic [CORE_W-1:0] core;
   } mjd_pick_type;

   function automatic logic [BUSY_W-1:0] busy_total(input logic [CORE_COUNT-1:0] busy);
      logic [BUSY_W-1:0] n;
      n = '0;
      for (int i = 0; i < CORE_COUNT; i++) begin
         n = n + BUSY_W'(busy[i]);
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ hdl/mjd_rr_pick.sv @@
// Round-robin idle core search starting after the last used core.
`timescale 1ns / 1ps
`default_nettype none

module mjd_rr_pick
   import mjd_pkg::*;
(
   input  wire logic [CORE_COUNT-1:0] busy,
   input  wire logic [CORE_W-1:0]     last_core,
   output mjd_pick_type               pick
);

   // highest offset first so the nearest idle core wins
   always_comb begin
      logic [CORE_W:0] pos;
      pick = '0;
      for (int n = CORE_COUNT; n >= 1; n--) begin
         pos = {1'b0, last_core} + (CORE_W + 1)'(n);
         if (pos >= (CORE_W + 1)'(CORE_COUNT)) begin
            pos = pos - (CORE_W + 1)'(CORE_COUNT);
         end
         if (!busy[pos[CORE_W-1:0]]) begin
            pick.found = 1'b1;
            pick.core  = pos[CORE_W-1:0];
         end
      end
   end

endmodule

`default_nettype wire

@@ hdl/multicore_job_dispatcher.sv @@
// Top level of the multicore job dispatcher.
`timescale 1ns / 1ps
`default_nettype none

// Dispatches tagged jobs over a pool of 8 cores with a 16-entry waiting FIFO.
// An arrival (tuser 0) starts on the next idle core after the last one used,
// else is queued, else dropped once queue_limit jobs wait (limit above 16
// acts as 16). A service end (tuser 1) or timeout (tuser 2) on a busy core
// reports finished/aborted and, if jobs wait, a second transfer starts the
// queue head; rsp_tlast marks the last result of each request. Other events
// give one "ignored" result. Flow: one request is in flight at a time; it
// is taken in IDLE, and the core-job and FIFO memories are read into
// registers at that transfer; in LOOKUP the first result is loaded into the
// output register once it is free, and a second result follows from SECOND
// the same way. The output register lets the next request be taken while
// the last result still waits.
// Memories need no clearing pass. Write queue_limit over csr only when idle.
module multicore_job_dispatcher
   import mjd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request: tdata = job_tag[15:0], core_index[18:16], zero pad
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // request: tuser = opcode[1:0]
   input  wire logic [OP_W-1:0]       req_tuser,
   // response: tdata = result_tag[15:0], result_core[18:16],
   //           waiting_length[23:19], busy_cores[27:24], zero pad
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,
   // response: tuser = action[2:0]
   output      logic [ACT_W-1:0]      rsp_tuser,
   output      logic                  rsp_tlast,
   // queue_limit register write
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [LIMIT_W-1:0]    csr_data
);

   // control state
   mjd_state_type           state_ff, state_in;
   logic [CORE_COUNT-1:0]   busy_ff, busy_in;
   logic [CORE_W-1:0]       last_ff, last_in;
   logic [PTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [LIMIT_W-1:0]      limit_ff;

   // captured request
   logic [OP_W-1:0]         op_ff;
   logic [TAG_W-1:0]        tag_ff;
   logic [CORE_W-1:0]       ci_ff;

   // memories and registered read data
   logic [TAG_W-1:0]        job_mem [CORE_COUNT];
   logic [TAG_W-1:0]        wait_mem [QUEUE_DEPTH];
   logic [TAG_W-1:0]        job_rd_ff;
   logic [TAG_W-1:0]        head_rd_ff;

   // output register and held second result
   logic                    rsp_valid_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic [ACT_W-1:0]        rsp_act_ff;
   logic                    rsp_last_ff;
   logic [RSP_DATA_W-1:0]   pend_data_ff, pend_data_in;

   // step controls
   logic                    req_xfer;
   logic                    out_free;
   logic                    step_go;
   logic                    second_go;
   logic                    need_second;
   logic                    job_we;
   logic [CORE_W-1:0]       job_wa;
   logic [TAG_W-1:0]        job_wd;
   logic                    wait_we;
   logic [RSP_DATA_W-1:0]   res_data;
   logic [ACT_W-1:0]        res_act;
   logic                    res_last;

   mjd_pick_type            pick_arr, pick_ref;
   logic [CORE_COUNT-1:0]   busy_freed;
   logic [CNT_W-1:0]        limit_eff;

   assign req_xfer  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_act_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign busy_freed = busy_ff & ~(CORE_COUNT'(1) << ci_ff);
   assign limit_eff  = (limit_ff > LIMIT_W'(QUEUE_DEPTH)) ? DEPTH_CNT : CNT_W'(limit_ff);

   mjd_rr_pick u_pick_arr (
      .busy      (busy_ff),
      .last_core (last_ff),
      .pick      (pick_arr)
   );

   // refill search runs with the event's core already freed
   mjd_rr_pick u_pick_ref (
      .busy      (busy_freed),
      .last_core (last_ff),
      .pick      (pick_ref)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_xfer) state_in = ST_LOOKUP;
         ST_LOOKUP: if (out_free) state_in = need_second ? ST_SECOND : ST_IDLE;
         ST_SECOND: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // step outputs and state updates
   always_comb begin
      logic [CNT_W-1:0] cnt_less;
      cnt_less     = count_ff - CNT_W'(1);
      req_tready   = (state_ff == ST_IDLE);
      step_go      = (state_ff == ST_LOOKUP) && out_free;
      second_go    = (state_ff == ST_SECOND) && out_free;
      need_second  = 1'b0;
      busy_in      = busy_ff;
      last_in      = last_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      count_in     = count_ff;
      job_we       = 1'b0;
      job_wa       = pick_arr.core;
      job_wd       = tag_ff;
      wait_we      = 1'b0;
      res_act      = ACT_IGNORED;
      res_last     = 1'b1;
      res_data     = '0;
      pend_data_in = pend_data_ff;

      if (op_ff == OP_ARRIVE) begin
         if (pick_arr.found) begin
            busy_in  = busy_ff | (CORE_COUNT'(1) << pick_arr.core);
            last_in  = pick_arr.core;
            job_we   = step_go;
            res_act  = ACT_STARTED;
            res_data = RSP_DATA_W'({busy_total(busy_in), count_ff, pick_arr.core, tag_ff});
         end else if (count_ff >= limit_eff) begin
            res_act  = ACT_DROPPED;
            res_data = RSP_DATA_W'({busy_total(busy_ff), count_ff, CORE_W'(0), tag_ff});
         end else begin
            wait_we   = step_go;
            wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
            count_in  = count_ff + CNT_W'(1);
            res_act   = ACT_QUEUED;
            res_data  = RSP_DATA_W'({busy_total(busy_ff), count_in, CORE_W'(0), tag_ff});
         end
      end else if (op_ff != OP_UNUSED && busy_ff[ci_ff]) begin
         res_act     = (op_ff == OP_END) ? ACT_FINISHED : ACT_ABORTED;
         need_second = (count_ff != '0);
         res_last    = !need_second;
         res_data    = RSP_DATA_W'({busy_total(busy_freed), count_ff, ci_ff, job_rd_ff});
         busy_in     = busy_freed;
         if (need_second) begin
            // freed core guarantees the search succeeds
            busy_in      = busy_freed | (CORE_COUNT'(1) << pick_ref.core);
            last_in      = pick_ref.core;
            rd_ptr_in    = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
            count_in     = cnt_less;
            job_we       = step_go;
            job_wa       = pick_ref.core;
            job_wd       = head_rd_ff;
            pend_data_in = RSP_DATA_W'({busy_total(busy_in), cnt_less, pick_ref.core,
                                        head_rd_ff});
         end
      end else begin
         res_data = RSP_DATA_W'({busy_total(busy_ff), count_ff,
                                 (op_ff == OP_UNUSED) ? CORE_W'(0) : ci_ff, TAG_W'(0)});
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         last_ff      <= '0;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) limit_ff <= csr_data;
         if (step_go) begin
            busy_ff   <= busy_in;
            last_ff   <= last_in;
            rd_ptr_ff <= rd_ptr_in;
            wr_ptr_ff <= wr_ptr_in;
            count_ff  <= count_in;
         end
         if (step_go || second_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= req_tuser;
         tag_ff <= req_tdata[TAG_W-1:0];
         ci_ff  <= req_tdata[TAG_W +: CORE_W];
      end
      if (step_go) begin
         rsp_data_ff  <= res_data;
         rsp_act_ff   <= res_act;
         rsp_last_ff  <= res_last;
         pend_data_ff <= pend_data_in;
      end else if (second_go) begin
         rsp_data_ff <= pend_data_ff;
         rsp_act_ff  <= ACT_STARTED;
         rsp_last_ff <= 1'b1;
      end
   end

   // core job memory: read at request transfer, written when a job starts
   always_ff @(posedge clock) begin
      if (job_we) job_mem[job_wa] <= job_wd;
      if (req_xfer) job_rd_ff <= job_mem[req_tdata[TAG_W +: CORE_W]];
   end

   // waiting FIFO memory: head read at request transfer
   always_ff @(posedge clock) begin
      if (wait_we) wait_mem[wr_ptr_ff] <= tag_ff;
      if (req_xfer) head_rd_ff <= wait_mem[rd_ptr_ff];
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("waiting count above queue depth");

   a_take_lookup: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_LOOKUP)
      else $error("request transfer not followed by lookup");

   a_queue_grows: assert property (@(posedge clock) disable iff (reset)
      (step_go && res_act == ACT_QUEUED) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queued job did not grow the queue");

   a_second_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SECOND |-> rsp_valid_ff && !rsp_last_ff)
      else $error("first of two results not pending during refill");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      second_go |=> rsp_data_ff[TAG_W + CORE_W + CNT_W +: BUSY_W] == busy_total(busy_ff))
      else $error("refill result busy count mismatch");

endmodule

`default_nettype wire

@@ verif/multicore_job_dispatcher_tb.sv @@
// Self-checking testbench for the multicore job dispatcher: directed table, then random traffic.
`timescale 1ns / 1ps

module multicore_job_dispatcher_tb;
   import mjd_pkg::*;

   // Run guard, far above the slowest legal run (about 1900 items with heavy idling).
   localparam int CYCLE_LIMIT = 500000;
   // Long receiver hold-off, enough to back the block up into its input.
   localparam int HOLD_CYCLES = 300;
   // Useful (non-ignored) items per random block.
   localparam int BLOCK_ITEMS = 300;

   // One result transfer as seen on rsp_*.
   typedef struct {
      mjd_action_type    act;
      logic [TAG_W-1:0]  tag;
      logic [CORE_W-1:0] core;
      logic [CNT_W-1:0]  wlen;
      logic [BUSY_W-1:0] busy;
      logic              last;
   } dispatch_result_t;

   typedef enum logic [1:0] {
      ROW_ITEM,     // expectation comes from the dispatch model
      ROW_CHECKED,  // single result, typed in the row
      ROW_CSR       // queue_limit write between items
   } row_kind_t;

   typedef struct {
      row_kind_t         kind;
      mjd_op_type        op;
      logic [TAG_W-1:0]  tag;
      logic [CORE_W-1:0] core;
      logic [LIMIT_W-1:0] limit;
      dispatch_result_t  res;
   } dir_row_t;

   // DUT ports; every input has a known value from time zero.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [OP_W-1:0]       req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [ACT_W-1:0]      rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [LIMIT_W-1:0]    csr_data   = '0;

   // Dispatcher state as the testbench tracks it.
   logic [CORE_COUNT-1:0] busy_mask;
   logic [TAG_W-1:0]      job_of_core [CORE_COUNT];
   int                    last_used;
   logic [TAG_W-1:0]      wait_tags [QUEUE_DEPTH];
   int                    rd_ptr;
   int                    wr_ptr;
   int                    wait_cnt;
   int                    queue_limit;

   dispatch_result_t      step_results[$];     // results of the item just taken
   dispatch_result_t      pending_results[$];  // in flight, oldest first
   dir_row_t              dir_rows[$];

   int                    err_count     = 0;
   int                    cycle_count   = 0;
   int                    send_idle_pct = 0;
   int                    recv_idle_pct = 0;
   int                    hold_token    = 0;   // bumped by stimulus to ask for a hold-off
   int                    hold_seen     = 0;
   int                    hold_left     = 0;

   multicore_job_dispatcher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Run guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model

   function automatic void reset_dispatch();
      busy_mask   = '0;
      last_used   = 0;
      rd_ptr      = 0;
      wr_ptr      = 0;
      wait_cnt    = 0;
      queue_limit = 16;
   endfunction

   // Round-robin: starts after the last used core, checks that core last.
   // Returns -1 when every core is busy.
   function automatic int find_idle_core();
      int c;
      c = last_used;
      for (int n = 0; n < CORE_COUNT; n++) begin
         c = (c + 1) % CORE_COUNT;
         if (!busy_mask[c]) return c;
      end
      return -1;
   endfunction

   // Snapshot of a result; queue length and busy count are taken after the update.
   function automatic dispatch_result_t make_result(mjd_action_type act, logic [TAG_W-1:0] tag,
                                                   int core, logic last);
      dispatch_result_t r;
      r.act  = act;
      r.tag  = tag;
      r.core = CORE_W'(core);
      r.wlen = CNT_W'(wait_cnt);
      r.busy = BUSY_W'($countones(busy_mask));
      r.last = last;
      return r;
   endfunction

   function automatic void occupy_core(int c, logic [TAG_W-1:0] tag);
      busy_mask[c]   = 1'b1;
      job_of_core[c] = tag;
      last_used      = c;
   endfunction

   // Applies one request to the tracked state and fills step_results.
   function automatic void dispatch_step(mjd_op_type op, logic [TAG_W-1:0] tag,
                                         logic [CORE_W-1:0] core);
      int               c;
      int               lim;
      logic [TAG_W-1:0] done_tag;
      logic [TAG_W-1:0] head;
      bit               more;
      step_results.delete();
      if (op == OP_ARRIVE) begin
         c   = find_idle_core();
         lim = (queue_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : queue_limit;
         if (c >= 0) begin
            occupy_core(c, tag);
            step_results.push_back(make_result(ACT_STARTED, tag, c, 1'b1));
         end else if (wait_cnt >= lim) begin
            step_results.push_back(make_result(ACT_DROPPED, tag, 0, 1'b1));
         end else begin
            wait_tags[wr_ptr] = tag;
            wr_ptr            = (wr_ptr + 1) % QUEUE_DEPTH;
            wait_cnt++;
            step_results.push_back(make_result(ACT_QUEUED, tag, 0, 1'b1));
         end
         return;
      end
      // unused opcode, or an event on an idle core: nothing changes
      if (op == OP_UNUSED || !busy_mask[core]) begin
         step_results.push_back(make_result(ACT_IGNORED, '0,
                                            (op == OP_UNUSED) ? 0 : int'(core), 1'b1));
         return;
      end
      done_tag        = job_of_core[core];
      more            = (wait_cnt > 0);
      busy_mask[core] = 1'b0;
      step_results.push_back(make_result((op == OP_END) ? ACT_FINISHED : ACT_ABORTED,
                                         done_tag, core, !more));
      if (!more) return;
      // queue head moves onto a core in a second transfer
      head   = wait_tags[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
      wait_cnt--;
      c = find_idle_core();
      if (c < 0) c = core;
      occupy_core(c, head);
      step_results.push_back(make_result(ACT_STARTED, head, c, 1'b1));
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
      err_count++;
   endtask

   task automatic check_result();
      dispatch_result_t want;
      if (pending_results.size() == 0) begin
         report_mismatch("unexpected result, action", rsp_tuser, 0);
         return;
      end
      want = pending_results.pop_front();
      if (rsp_tuser != want.act)           report_mismatch("action", rsp_tuser, want.act);
      if (rsp_tdata[15:0] != want.tag)     report_mismatch("result_tag", rsp_tdata[15:0], want.tag);
      if (rsp_tdata[18:16] != want.core)   report_mismatch("result_core", rsp_tdata[18:16], want.core);
      if (rsp_tdata[23:19] != want.wlen)   report_mismatch("waiting_length", rsp_tdata[23:19],
                                                           want.wlen);
      if (rsp_tdata[27:24] != want.busy)   report_mismatch("busy_cores", rsp_tdata[27:24], want.busy);
      if (rsp_tlast != want.last)          report_mismatch("last", rsp_tlast, want.last);
   endtask

   // Result side: checks each transfer, then picks the next tready.
   // A hold-off request from the stimulus keeps tready low for the whole hold-off.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offers one request after random idle cycles, waits for the transfer,
   // then queues either the typed or the modeled expectation.
   task automatic send_item(input mjd_op_type op, input logic [TAG_W-1:0] tag,
                            input logic [CORE_W-1:0] core, input bit typed,
                            input dispatch_result_t typed_res, output mjd_action_type first_act);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_W'({core, tag});
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      dispatch_step(op, tag, core);
      first_act = step_results[0].act;
      if (typed) begin
         pending_results.push_back(typed_res);
      end else begin
         foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
   endtask

   // Sender stops and waits until every expected result has come, then
   // idles on so the last one can leave the pipeline.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid   <= 1'b0;
      queue_limit = value;
   endtask

   task automatic send_random(input int arrive_pct, output bit useful);
      int                roll;
      mjd_op_type        op;
      logic [TAG_W-1:0]  tag;
      logic [CORE_W-1:0] core;
      mjd_action_type    act;
      dispatch_result_t  unused_res;
      roll = $urandom_range(99);
      tag  = TAG_W'($urandom);
      core = CORE_W'($urandom);
      if (roll < arrive_pct)  op = OP_ARRIVE;
      else if (roll < 80)     op = OP_END;
      else if (roll < 96)     op = OP_TIMEOUT;
      else                    op = OP_UNUSED;
      // most events target a busy core so that jobs actually retire
      if ((op == OP_END || op == OP_TIMEOUT) && busy_mask != '0 && $urandom_range(99) < 88) begin
         do core = CORE_W'($urandom); while (!busy_mask[core]);
      end
      send_item(op, tag, core, 1'b0, unused_res, act);
      useful = (act != ACT_IGNORED);
   endtask

   // ---------------------------------------------------------------- directed table

   function automatic dir_row_t item_row(mjd_op_type op, logic [TAG_W-1:0] tag,
                                         logic [CORE_W-1:0] core);
      dir_row_t r;
      r.kind = ROW_ITEM;
      r.op   = op;
      r.tag  = tag;
      r.core = core;
      return r;
   endfunction

   function automatic dir_row_t checked_row(mjd_op_type op, logic [TAG_W-1:0] tag,
                                            logic [CORE_W-1:0] core, mjd_action_type act,
                                            logic [TAG_W-1:0] rtag, logic [CORE_W-1:0] rcore,
                                            logic [CNT_W-1:0] wlen, logic [BUSY_W-1:0] busy);
      dir_row_t r;
      r           = item_row(op, tag, core);
      r.kind      = ROW_CHECKED;
      r.res.act   = act;
      r.res.tag   = rtag;
      r.res.core  = rcore;
      r.res.wlen  = wlen;
      r.res.busy  = busy;
      r.res.last  = 1'b1;
      return r;
   endfunction

   function automatic dir_row_t csr_row(logic [LIMIT_W-1:0] value);
      dir_row_t r;
      r       = item_row(OP_UNUSED, '0, '0);
      r.kind  = ROW_CSR;
      r.limit = value;
      return r;
   endfunction

   function automatic void build_directed();
      // events with nothing to act on after reset
      dir_rows.push_back(checked_row(OP_END,     16'h0000, 3'd0, ACT_IGNORED, 16'h0, 3'd0, 0, 0));
      dir_rows.push_back(checked_row(OP_UNUSED,  16'hFFFF, 3'd7, ACT_IGNORED, 16'h0, 3'd0, 0, 0));
      dir_rows.push_back(checked_row(OP_TIMEOUT, 16'h0000, 3'd7, ACT_IGNORED, 16'h0, 3'd7, 0, 0));
      // first job goes to core 1: search starts after last_core = 0
      dir_rows.push_back(checked_row(OP_ARRIVE, 16'h0000, 3'd7, ACT_STARTED, 16'h0000, 3'd1, 0, 1));
      dir_rows.push_back(checked_row(OP_ARRIVE, 16'hFFFF, 3'd0, ACT_STARTED, 16'hFFFF, 3'd2, 0, 2));
      // fill the pool; the last one wraps around to core 0
      dir_rows.push_back(item_row(OP_ARRIVE, 16'h0001, 3'd3));
      dir_rows.push_back(item_row(OP_ARRIVE, 16'h8000, 3'd5));
      dir_rows.push_back(item_row(OP_ARRIVE, 16'h00FF, 3'd0));
      dir_rows.push_back(item_row(OP_ARRIVE, 16'hFF00, 3'd7));
      dir_rows.push_back(item_row(OP_ARRIVE, 16'h5555, 3'd2));
      dir_rows.push_back(item_row(OP_ARRIVE, 16'hAAAA, 3'd4));
      // zero limit: every job is dropped once the pool is busy
      dir_rows.push_back(csr_row(5'd0));
      dir_rows.push_back(checked_row(OP_ARRIVE, 16'h5A5A, 3'd1, ACT_DROPPED, 16'h5A5A, 3'd0, 0, 8));
      // limit above the depth acts as the full depth
      dir_rows.push_back(csr_row(5'd31));
      dir_rows.push_back(checked_row(OP_ARRIVE, 16'h1234, 3'd6, ACT_QUEUED, 16'h1234, 3'd0, 1, 8));
      dir_rows.push_back(checked_row(OP_ARRIVE, 16'hABCD, 3'd3, ACT_QUEUED, 16'hABCD, 3'd0, 2, 8));
      // finish and abort with waiting jobs: two transfers each
      dir_rows.push_back(item_row(OP_END,     16'hFFFF, 3'd3));
      dir_rows.push_back(item_row(OP_TIMEOUT, 16'h0000, 3'd5));
      // empty queue: single result carrying last
      dir_rows.push_back(item_row(OP_TIMEOUT, 16'h1111, 3'd0));
      dir_rows.push_back(csr_row(5'd1));
      dir_rows.push_back(item_row(OP_ARRIVE, 16'h2222, 3'd0));
      dir_rows.push_back(item_row(OP_ARRIVE, 16'h3333, 3'd0));
      dir_rows.push_back(checked_row(OP_ARRIVE, 16'h4444, 3'd0, ACT_DROPPED, 16'h4444, 3'd0, 1, 8));
      dir_rows.push_back(item_row(OP_END,     16'h0000, 3'd1));
      dir_rows.push_back(item_row(OP_TIMEOUT, 16'hFFFF, 3'd7));
   endfunction

   // ---------------------------------------------------------------- main sequence

   initial begin
      int             limits [6];
      int             arrive_pcts [6];
      int             done_items;
      bit             useful;
      mjd_action_type act;

      limits      = '{16, 3, 2, 17, 0, 8};
      arrive_pcts = '{55, 50, 60, 45, 55, 50};
      limits[4]   = $urandom_range(0, 31);

      reset_dispatch();
      build_directed();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, both sides always ready
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            write_limit(dir_rows[i].limit);
         end else begin
            send_item(dir_rows[i].op, dir_rows[i].tag, dir_rows[i].core,
                      dir_rows[i].kind == ROW_CHECKED, dir_rows[i].res, act);
         end
      end

      // random part: blocks 0-1 receiver idles more, 2-3 sender idles more,
      // 4-5 neither idles
      for (int blk = 0; blk < 6; blk++) begin
         write_limit(LIMIT_W'(limits[blk]));
         send_idle_pct = (blk < 2) ? 10 : (blk < 4) ? 76 : 0;
         recv_idle_pct = (blk < 2) ? 76 : (blk < 4) ? 10 : 0;
         // long receiver stall while the sender keeps offering
         if (blk == 0 || blk == 4) hold_token <= hold_token + 1;
         done_items = 0;
         while (done_items < BLOCK_ITEMS) begin
            send_random(arrive_pcts[blk], useful);
            if (useful) done_items++;
            // sender pauses mid-block until the pipeline is empty
            if (blk == 2 && useful && done_items == BLOCK_ITEMS / 2) wait_drained();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("results missing, count", 0, pending_results.size());

      if (err_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
